FILE: rtl/core/gbs_pkg.sv
package gbs_pkg;

    localparam int MAX_KEPT = 64;
    localparam int KEPT_AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int KEPT_CW  = $clog2(MAX_KEPT + 1);

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAP_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_AGNOSTIC    = CFG_INDEX_W'(1);

    localparam logic [15:0] OVERLAP_THRESHOLD_RESET = 16'd29491;
    localparam logic        CLASS_AGNOSTIC_RESET    = 1'b1;

    typedef struct packed {
        logic               frame_start;
        logic signed [15:0] left_edge;
        logic signed [15:0] top_edge;
        logic signed [15:0] right_edge;
        logic signed [15:0] bottom_edge;
        logic [7:0]         class_label;
    } in_item_t;

    typedef struct packed {
        logic [15:0] box_number;
        logic        keep;
        logic        table_full;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] left_edge;
        logic signed [15:0] top_edge;
        logic signed [15:0] right_edge;
        logic signed [15:0] bottom_edge;
        logic [7:0]         class_label;
        logic [31:0]        area;
    } kept_entry_t;

    typedef struct packed {
        logic load;
        logic area;
        logic issue;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

    // hi - lo when positive, else zero
    function automatic logic [15:0] extent(input logic signed [15:0] lo,
                                           input logic signed [15:0] hi);
        logic signed [16:0] diff;
        diff = {hi[15], hi} - {lo[15], lo};
        return (hi > lo) ? diff[15:0] : 16'd0;
    endfunction

    function automatic logic signed [15:0] smax(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [15:0] smin(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: rtl/core/gbs_ram.sv
module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: rtl/core/gbs_ctrl.sv
module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_AREA   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                cmd.area   = 1'b1;
                state_next = status.total_zero ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/gbs_datapath.sv
module gbs_datapath
    import gbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in_item,
    input  logic [15:0] overlap_threshold,
    input  logic        class_agnostic,
    input  ctl_cmd_t    cmd,
    output dp_status_t  status,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    in_item_t            box_reg;
    logic [31:0]         area_reg;
    logic                keep_reg;
    logic [KEPT_CW-1:0]  kept_total_reg;
    logic [15:0]         box_counter_reg;
    logic [KEPT_AW-1:0]  rd_addr_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    kept_entry_t         rd_entry;
    kept_entry_t         wr_entry;
    logic                wr_en;
    logic                table_full;

    // compare pipeline
    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [15:0]         ix2_reg, iy2_reg;
    logic                match2_reg, match3_reg, match4_reg, match5_reg;
    logic [31:0]         karea2_reg, karea3_reg;
    logic [31:0]         inter3_reg, inter4_reg, inter5_reg;
    logic [32:0]         union4_reg;
    logic [48:0]         prod5_reg;
    logic                suppress5;

    assign table_full = (kept_total_reg == KEPT_CW'(MAX_KEPT));
    assign wr_en      = cmd.finish && keep_reg && !table_full;

    always_comb
    begin
        wr_entry.left_edge   = box_reg.left_edge;
        wr_entry.top_edge    = box_reg.top_edge;
        wr_entry.right_edge  = box_reg.right_edge;
        wr_entry.bottom_edge = box_reg.bottom_edge;
        wr_entry.class_label = box_reg.class_label;
        wr_entry.area        = area_reg;
    end

    gbs_ram #(
        .WIDTH ($bits(kept_entry_t)),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (kept_total_reg[KEPT_AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_entry)
    );

    assign suppress5 = v5_reg && match5_reg && ({1'b0, inter5_reg, 16'h0000} > prod5_reg);

    assign status.total_zero = (kept_total_reg == '0);
    assign status.scan_last  = (KEPT_CW'(rd_addr_reg) == (kept_total_reg - KEPT_CW'(1)));
    assign status.pipe_busy  = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_total_reg  <= '0;
            box_counter_reg <= '0;
            rd_addr_reg     <= '0;
            keep_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;

            if (cmd.load)
            begin
                keep_reg    <= 1'b1;
                rd_addr_reg <= '0;
                if (in_item.frame_start)
                begin
                    kept_total_reg  <= '0;
                    box_counter_reg <= '0;
                end
            end
            else if (suppress5)
            begin
                keep_reg <= 1'b0;
            end

            if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_reg + KEPT_AW'(1);
            end

            if (wr_en)
            begin
                kept_total_reg <= kept_total_reg + KEPT_CW'(1);
            end

            if (cmd.finish)
            begin
                box_counter_reg <= box_counter_reg + 16'd1;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            box_reg <= in_item;
        end
        if (cmd.area)
        begin
            area_reg <= extent(box_reg.left_edge, box_reg.right_edge)
                      * extent(box_reg.top_edge, box_reg.bottom_edge);
        end

        ix2_reg    <= extent(smax(box_reg.left_edge, rd_entry.left_edge),
                             smin(box_reg.right_edge, rd_entry.right_edge));
        iy2_reg    <= extent(smax(box_reg.top_edge, rd_entry.top_edge),
                             smin(box_reg.bottom_edge, rd_entry.bottom_edge));
        match2_reg <= class_agnostic || (rd_entry.class_label == box_reg.class_label);
        karea2_reg <= rd_entry.area;

        inter3_reg <= ix2_reg * iy2_reg;
        karea3_reg <= karea2_reg;
        match3_reg <= match2_reg;

        union4_reg <= {1'b0, area_reg} + {1'b0, karea3_reg} - {1'b0, inter3_reg};
        inter4_reg <= inter3_reg;
        match4_reg <= match3_reg;

        prod5_reg  <= 49'(overlap_threshold) * 49'(union4_reg);
        inter5_reg <= inter4_reg;
        match5_reg <= match4_reg;

        if (cmd.finish)
        begin
            out_reg.box_number <= box_counter_reg;
            out_reg.keep       <= keep_reg;
            out_reg.table_full <= keep_reg && table_full;
        end
    end

endmodule

FILE: rtl/core/greedy_box_suppression.sv
// Greedy IoU non-maximum suppression over boxes sorted by descending score.
// Each item is one box; each gives one result (box number, keep, table_full).
// The kept-box RAM is read one entry per cycle into a five-stage compare
// pipeline, so the time for an item grows with kept, the number of boxes
// stored in the frame when the item starts (after a frame start clears the
// table; at most MAX_KEPT). The item is loaded, its area is computed, the
// kept entries are scanned and the pipeline drained (both skipped when kept
// is 0), and the result is registered, after which the next item can be
// accepted. A new item is taken while the previous result still waits on
// the output; its own result then waits until the output is free.
module greedy_box_suppression
    import gbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [15:0] overlap_threshold_reg;
    logic        class_agnostic_reg;
    ctl_cmd_t    cmd;
    dp_status_t  status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_threshold_reg <= OVERLAP_THRESHOLD_RESET;
            class_agnostic_reg    <= CLASS_AGNOSTIC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OVERLAP_THRESHOLD: overlap_threshold_reg <= cfg_data[15:0];
                REG_CLASS_AGNOSTIC:    class_agnostic_reg    <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gbs_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_item           (in_item),
        .overlap_threshold (overlap_threshold_reg),
        .class_agnostic    (class_agnostic_reg),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_item          (out_item)
    );

endmodule
